/* rtl/min_turn_duration_defines.svh */
// ----------------------------------------------------------------------------
// min_turn_duration_defines
// Assertion macros shared by the minimum turn duration design files.
// ----------------------------------------------------------------------------
`ifndef MIN_TURN_DURATION_DEFINES_SVH
`define MIN_TURN_DURATION_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MTD_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, checked out of reset
`define MTD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* rtl/mtd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtd_pkg
// Widths, register indexes and job types for the minimum turn duration block.
// ----------------------------------------------------------------------------
package mtd_pkg;

  localparam int FRAC      = 16;
  localparam int ANG_W     = 20;
  localparam int SPD_W     = 24;
  localparam int ACC_W     = 28;
  localparam int DUR_W     = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 28;

  localparam int PRD_W     = ANG_W + ACC_W;      // angle * accel, speed^2
  localparam int SUM_W     = PRD_W + 1;
  localparam int DEN_W     = ACC_W + SPD_W;      // accel * speed
  localparam int REM_W     = DEN_W;
  localparam int NQ_W      = 56;                 // dividend / quotient shifter
  localparam int TRI_SHIFT = 2 * FRAC + 2;       // 4 * angle * 2^(2F)
  localparam int DIV_BITS  = 2;                  // quotient bits per cycle
  localparam int SQ_BITS   = 2;                  // root bits per cycle
  localparam int SQ_W      = NQ_W;
  localparam int DIV_TRI_CYC  = NQ_W / DIV_BITS;
  localparam int DIV_TRAP_CYC = DUR_W / DIV_BITS;
  localparam int SQRT_CYC     = (NQ_W / 2) / SQ_BITS;
  localparam int CNT_W        = 5;

  localparam int JOB_DEPTH_DEF = 4;
  localparam int OUT_DEPTH     = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PEAK_SPEED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL      = 2'd1;

  typedef enum logic [1:0] {
    JOB_ZERO,
    JOB_TRI,
    JOB_TRAP,
    JOB_SAT
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [REM_W-1:0]  rem;
    logic [NQ_W-1:0]   nq;
    logic [DEN_W-1:0]  den;
  } job_t;

  typedef struct packed {
    logic [DUR_W-1:0] dur;
    logic             cruise;
  } res_t;

endpackage

/* rtl/min_turn_duration.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// min_turn_duration
// Minimum rest-to-rest turn time under a peak angular speed and acceleration.
// ----------------------------------------------------------------------------
// A three-stage front pipeline takes one angle per cycle while it is not
// stalled, forms the products and classifies the request into a job queue;
// the back end works one job at a time. Zero-angle, zero-acceleration and
// saturated requests go straight to a result; trapezoidal requests take a
// 2-bit-per-step restoring division, triangular ones a division and a square
// root. The back end's shared divider and root unit set the sustained rate;
// the job queue and a two-entry result queue let either side stall on its own.
// cfg_ready is always high; write limits only while no request is in flight.
module min_turn_duration import mtd_pkg::*; #(
  parameter int JOB_DEPTH = JOB_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [ANG_W-1:0]     in_turn_angle,
  input  logic                 out_pop,
  output logic                 out_empty,
  output logic [DUR_W-1:0]     out_duration,
  output logic                 out_reached_cruise
);

  job_t job_wr;
  job_t job_rd;
  logic job_push;
  logic job_full;
  logic job_pop;
  logic job_empty;
  res_t res_wr;
  res_t res_rd;
  logic res_push;
  logic res_full;

  assign cfg_ready          = 1'b1;
  assign out_duration       = res_rd.dur;
  assign out_reached_cruise = res_rd.cruise;

  mtd_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_valid     (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .in_push       (in_push),
    .in_turn_angle (in_turn_angle),
    .in_full       (in_full),
    .job_push      (job_push),
    .job           (job_wr),
    .job_full      (job_full)
  );

  mtd_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (JOB_DEPTH)
  ) u_job_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (job_push),
    .wr_data (job_wr),
    .full    (job_full),
    .pop     (job_pop),
    .rd_data (job_rd),
    .empty   (job_empty)
  );

  mtd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_empty (job_empty),
    .job       (job_rd),
    .job_pop   (job_pop),
    .res_push  (res_push),
    .res       (res_wr),
    .res_full  (res_full)
  );

  mtd_fifo #(
    .WIDTH ($bits(res_t)),
    .DEPTH (OUT_DEPTH)
  ) u_res_q (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (res_push),
    .wr_data (res_wr),
    .full    (res_full),
    .pop     (out_pop),
    .rd_data (res_rd),
    .empty   (out_empty)
  );

endmodule

/* rtl/mtd_fifo.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtd_fifo
// Small first-in first-out queue with push/full and pop/empty sides.
// ----------------------------------------------------------------------------
`include "min_turn_duration_defines.svh"

module mtd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    cnt_r;
  logic             do_push;
  logic             do_pop;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  `MTD_ASSERT_IMPL(a_cnt_bound, 1'b1, cnt_r <= CW'(DEPTH))
  `MTD_ASSERT_NEXT(a_cnt_up, (push && !full && !pop), cnt_r == $past(cnt_r) + 1'b1)
  `MTD_ASSERT_NEXT(a_cnt_down, (pop && !empty && !push), cnt_r == $past(cnt_r) - 1'b1)

endmodule

/* rtl/mtd_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtd_front
// Holds the limits, takes angles, forms the products and classifies each
// request into a job for the back end.
// ----------------------------------------------------------------------------
module mtd_front import mtd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_valid,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DAT_W-1:0] cfg_wdata,
  input  logic                 in_push,
  input  logic [ANG_W-1:0]     in_turn_angle,
  output logic                 in_full,
  output logic                 job_push,
  output job_t                 job,
  input  logic                 job_full
);

  logic [SPD_W-1:0] speed_r;
  logic [ACC_W-1:0] accel_r;

  logic             en;
  logic             vld_a_r;
  logic [ANG_W-1:0] mag_a_r;
  logic             vld_b_r;
  logic [ANG_W-1:0] mag_b_r;
  logic [PRD_W-1:0] aa_b_r;
  logic [PRD_W-1:0] vv_b_r;
  logic [DEN_W-1:0] av_b_r;
  logic             zero_b_r;
  logic             vzero_b_r;
  logic             vld_c_r;
  job_t             job_c_r;
  job_t             job_nxt;
  logic [SUM_W-1:0] sum;
  logic [ANG_W-1:0] mag;

  // whole pipe moves together; it only stops when the last stage cannot drain
  assign en       = !vld_c_r || !job_full;
  assign in_full  = !en;
  assign job_push = vld_c_r && !job_full;
  assign job      = job_c_r;
  assign mag      = in_turn_angle[ANG_W-1] ? (~in_turn_angle + 1'b1) : in_turn_angle;
  assign sum      = {1'b0, aa_b_r} + {1'b0, vv_b_r};

  always_comb begin
    job_nxt      = '0;
    job_nxt.den  = av_b_r;
    job_nxt.rem  = REM_W'(sum[SUM_W-1:FRAC]);
    job_nxt.nq   = {sum[FRAC-1:0], (NQ_W - FRAC)'(0)};
    priority if (zero_b_r) begin
      job_nxt.kind = JOB_ZERO;
    end else if (vzero_b_r || (aa_b_r <= vv_b_r)) begin
      job_nxt.kind = JOB_TRI;
      job_nxt.rem  = '0;
      job_nxt.den  = DEN_W'(accel_r);
      job_nxt.nq   = NQ_W'({mag_b_r, TRI_SHIFT'(0)});
    end else if (DEN_W'(sum[SUM_W-1:FRAC]) >= av_b_r) begin
      // quotient would need more than DUR_W bits
      job_nxt.kind = JOB_SAT;
    end else begin
      job_nxt.kind = JOB_TRAP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      speed_r <= '0;
      accel_r <= '0;
    end else if (cfg_valid) begin
      if (cfg_index == REG_PEAK_SPEED) begin
        speed_r <= cfg_wdata[SPD_W-1:0];
      end else if (cfg_index == REG_ACCEL) begin
        accel_r <= cfg_wdata[ACC_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_a_r <= 1'b0;
      vld_b_r <= 1'b0;
      vld_c_r <= 1'b0;
    end else if (en) begin
      vld_a_r <= in_push;
      vld_b_r <= vld_a_r;
      vld_c_r <= vld_b_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mag_a_r   <= mag;
      mag_b_r   <= mag_a_r;
      aa_b_r    <= mag_a_r * accel_r;
      vv_b_r    <= PRD_W'(speed_r * speed_r);
      av_b_r    <= accel_r * speed_r;
      zero_b_r  <= (mag_a_r == '0) || (accel_r == '0);
      vzero_b_r <= (speed_r == '0);
      job_c_r   <= job_nxt;
    end
  end

endmodule

/* rtl/mtd_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtd_back
// Runs one job at a time: a fixed result for zero and saturated jobs, else
// restoring division, then a digit-by-digit square root for triangular jobs.
// ----------------------------------------------------------------------------
`include "min_turn_duration_defines.svh"

module mtd_back import mtd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic job_empty,
  input  job_t job,
  output logic job_pop,
  output logic res_push,
  output res_t res,
  input  logic res_full
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SQRT,
    ST_DONE
  } st_t;

  st_t              st_r;
  kind_t            kind_r;
  logic [REM_W-1:0] rem_r;
  logic [NQ_W-1:0]  nq_r;
  logic [DEN_W-1:0] den_r;
  logic [SQ_W-1:0]  sn_r;
  logic [SQ_W-1:0]  sres_r;
  logic [SQ_W-1:0]  sbit_r;
  logic [CNT_W-1:0] cnt_r;
  res_t             res_r;

  logic [REM_W-1:0] rem_nxt;
  logic [NQ_W-1:0]  nq_nxt;
  logic [SQ_W-1:0]  sn_nxt;
  logic [SQ_W-1:0]  sres_nxt;
  logic [SQ_W-1:0]  sbit_nxt;

  assign job_pop  = (st_r == ST_IDLE) && !job_empty;
  assign res_push = (st_r == ST_DONE);
  assign res      = res_r;

  // restoring division, DIV_BITS quotient bits per cycle
  always_comb begin
    logic [REM_W:0] r2;
    rem_nxt = rem_r;
    nq_nxt  = nq_r;
    for (int k = 0; k < DIV_BITS; k++) begin
      r2     = {rem_nxt, nq_nxt[NQ_W-1]};
      nq_nxt = {nq_nxt[NQ_W-2:0], 1'b0};
      if (r2 >= {1'b0, den_r}) begin
        r2        = r2 - {1'b0, den_r};
        nq_nxt[0] = 1'b1;
      end
      rem_nxt = r2[REM_W-1:0];
    end
  end

  // integer square root, one root bit per step
  always_comb begin
    logic [SQ_W-1:0] t;
    sn_nxt   = sn_r;
    sres_nxt = sres_r;
    sbit_nxt = sbit_r;
    for (int k = 0; k < SQ_BITS; k++) begin
      t = sres_nxt + sbit_nxt;
      if (sn_nxt >= t) begin
        sn_nxt   = sn_nxt - t;
        sres_nxt = (sres_nxt >> 1) + sbit_nxt;
      end else begin
        sres_nxt = sres_nxt >> 1;
      end
      sbit_nxt = sbit_nxt >> 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
    end else begin
      unique case (st_r)
        ST_IDLE: begin
          if (!job_empty) begin
            kind_r <= job.kind;
            rem_r  <= job.rem;
            nq_r   <= job.nq;
            den_r  <= job.den;
            cnt_r  <= (job.kind == JOB_TRI) ? CNT_W'(DIV_TRI_CYC - 1)
                                            : CNT_W'(DIV_TRAP_CYC - 1);
            unique case (job.kind)
              JOB_ZERO: begin
                res_r <= '{dur: '0, cruise: 1'b0};
                st_r  <= ST_DONE;
              end
              JOB_SAT: begin
                res_r <= '{dur: '1, cruise: 1'b1};
                st_r  <= ST_DONE;
              end
              JOB_TRI, JOB_TRAP: begin
                st_r <= ST_DIV;
              end
              default: begin
                st_r <= ST_IDLE;
              end
            endcase
          end
        end
        ST_DIV: begin
          rem_r <= rem_nxt;
          nq_r  <= nq_nxt;
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            if (kind_r == JOB_TRI) begin
              sn_r   <= nq_nxt;
              sres_r <= '0;
              sbit_r <= SQ_W'(1) << (SQ_W - 2);
              cnt_r  <= CNT_W'(SQRT_CYC - 1);
              st_r   <= ST_SQRT;
            end else begin
              res_r <= '{dur: nq_nxt[DUR_W-1:0], cruise: 1'b1};
              st_r  <= ST_DONE;
            end
          end
        end
        ST_SQRT: begin
          sn_r   <= sn_nxt;
          sres_r <= sres_nxt;
          sbit_r <= sbit_nxt;
          cnt_r  <= cnt_r - 1'b1;
          if (cnt_r == '0) begin
            res_r <= '{dur: sres_nxt[DUR_W-1:0], cruise: 1'b0};
            st_r  <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!res_full) begin
            st_r <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
    end
  end

  `MTD_ASSERT_IMPL(a_rem_below_den, (st_r == ST_DIV), rem_r < den_r)
  `MTD_ASSERT_NEXT(a_done_drains, (st_r == ST_DONE && !res_full), st_r == ST_IDLE)
  `MTD_ASSERT_IMPL(a_pop_when_idle, job_pop, st_r == ST_IDLE)

endmodule
